FILE: rtl/assert_macros.svh
// assertion macros used by nibble_map_code_start_lookup
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold on every rising clock edge outside reset
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/nmcs_pkg.sv
// types and constants of the nibble map code start lookup
// no dependencies
`default_nettype none
package nmcs_pkg;

    localparam int NIB_W      = 4;
    localparam int NIBS       = 8;
    localparam int TOP_SHIFT  = 28;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 12;
    localparam int OFF_W      = 21;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_BELOW_BASE = 2'd2
    } t_status;

    // result of the nibble search over one map word
    typedef struct packed {
        logic             found;
        logic [2:0]       sel;
        logic [NIB_W-1:0] value;
    } t_nib_hit;

endpackage
`default_nettype wire

FILE: rtl/nibble_map_code_start_lookup.sv
// code start lookup over a nibble map: a load writes the map, busy stays low.
// a query scans w words (1 <= w <= SCAN_WORDS) while busy, then passes through S_ADD
// when a start is found; the strobe follows the last busy cycle.
// rate is one map word per cycle, set by the single read port of the map memory.
// synchronous active-low reset clears the state, the word count and the strobe; map is not cleared.
`default_nettype none
`include "assert_macros.svh"
module nibble_map_code_start_lookup #(
    parameter int MAP_ENTRIES = 4096,
    parameter int SCAN_WORDS  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [11:0] i_entry_index,
    input  wire logic [31:0] i_entry_value,
    input  wire logic [63:0] i_code_base,
    input  wire logic [19:0] i_pc_offset,
    output logic             o_result_valid,
    output logic [63:0]      o_fn_start,
    output logic [1:0]       o_status
);

    localparam int AW   = (MAP_ENTRIES > 2) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CNTW = $clog2(SCAN_WORDS + 1);
    localparam int IW   = nmcs_pkg::IDX_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ADD} t_state;

    t_state                       r_state, n_state;
    logic [IW-1:0]                r_idx, n_idx;
    logic [2:0]                   r_nib, n_nib;
    logic                         r_first, n_first;
    logic [CNTW-1:0]              r_count, n_count;
    logic [63:0]                  r_base, n_base;
    logic [nmcs_pkg::OFF_W-1:0]   r_off, n_off;
    logic                         r_valid, n_valid;
    logic [63:0]                  r_start, n_start;
    nmcs_pkg::t_status            r_status, n_status;

    logic [nmcs_pkg::WORD_W-1:0]  mem [MAP_ENTRIES];
    logic [nmcs_pkg::WORD_W-1:0]  r_rdata;
    logic                         r_rd_ok;
    logic [IW-1:0]                rd_idx;
    logic                         rd_ok;
    logic                         wr_en;
    logic                         take;
    logic [nmcs_pkg::WORD_W-1:0]  word;
    nmcs_pkg::t_nib_hit           hit;

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    // map memory: one write port for loads, one registered read port for the scan
    assign rd_idx = (r_state == S_IDLE) ? i_pc_offset[19:8] : (r_idx - 1'b1);
    assign rd_ok  = ({20'd0, rd_idx} < 32'(MAP_ENTRIES));
    assign wr_en  = take && (i_command == nmcs_pkg::CMD_LOAD)
                    && ({20'd0, i_entry_index} < 32'(MAP_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_entry_index)] <= i_entry_value;
        end
        if (rd_ok) begin
            r_rdata <= mem[AW'(rd_idx)];
        end
        r_rd_ok <= rd_ok;
    end

    // words beyond the table read as zero
    assign word = r_rd_ok ? r_rdata : '0;

    nmcs_nib_find u_find (
        .i_word (word),
        .i_top  (r_first ? r_nib : 3'd7),
        .o_hit  (hit)
    );

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_nib    = r_nib;
        n_first  = r_first;
        n_count  = r_count;
        n_base   = r_base;
        n_off    = r_off;
        n_valid  = 1'b0;
        n_start  = r_start;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (take && (i_command == nmcs_pkg::CMD_QUERY)) begin
                    n_state = S_SCAN;
                    n_idx   = i_pc_offset[19:8];
                    n_nib   = i_pc_offset[7:5];
                    n_first = 1'b1;
                    n_count = CNTW'(1);
                    n_base  = i_code_base;
                end
            end
            S_SCAN: begin
                if (hit.found) begin
                    // byte offset of the marked start from the code base
                    n_off   = {1'b0, r_idx, 8'd0}
                              + {13'd0, hit.sel, 5'd0}
                              + {15'd0, hit.value - 4'd1, 2'd0};
                    n_state = S_ADD;
                end else if (r_count == CNTW'(SCAN_WORDS)) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_start  = '0;
                    n_status = nmcs_pkg::ST_TOO_LARGE;
                end else if (r_idx == '0) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_start  = '0;
                    n_status = nmcs_pkg::ST_BELOW_BASE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_first = 1'b0;
                    n_count = r_count + 1'b1;
                end
            end
            S_ADD: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_start  = r_base + 64'(r_off);
                n_status = nmcs_pkg::ST_OK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_nib    <= n_nib;
        r_first  <= n_first;
        r_base   <= n_base;
        r_off    <= n_off;
        r_start  <= n_start;
        r_status <= n_status;
    end

    assign o_result_valid = r_valid;
    assign o_fn_start     = r_start;
    assign o_status       = r_status;

    // checks
    `ASSERT_SYNC(a_strobe_idle, i_clk, i_rst_n, o_result_valid |-> !busy)
    `ASSERT_SYNC(a_fail_zero, i_clk, i_rst_n,
        (o_result_valid && (o_status != nmcs_pkg::ST_OK)) |-> (o_fn_start == '0))
    `ASSERT_NEVER(a_count_limit, i_clk, i_rst_n, r_count > CNTW'(SCAN_WORDS))
    `ASSERT_SYNC(a_query_busy, i_clk, i_rst_n,
        (take && (i_command == nmcs_pkg::CMD_QUERY)) |=> busy)
    `ASSERT_SYNC(a_load_quiet, i_clk, i_rst_n,
        (take && (i_command == nmcs_pkg::CMD_LOAD)) |=> (!busy && !o_result_valid))

endmodule
`default_nettype wire

FILE: rtl/nmcs_nib_find.sv
// finds the nonzero nibble with the highest index at or below a limit in one word
// depends on nmcs_pkg
`default_nettype none
module nmcs_nib_find (
    input  wire logic [nmcs_pkg::WORD_W-1:0] i_word,
    input  wire logic [2:0]                  i_top,
    output nmcs_pkg::t_nib_hit               o_hit
);

    // later nibbles override earlier ones, so the match with the highest index wins
    always_comb begin
        logic [nmcs_pkg::NIB_W-1:0] nib;
        o_hit = '0;
        for (int j = 0; j < nmcs_pkg::NIBS; j++) begin
            nib = i_word[(nmcs_pkg::TOP_SHIFT - nmcs_pkg::NIB_W*j) +: nmcs_pkg::NIB_W];
            if ((3'(j) <= i_top) && (nib != '0)) begin
                o_hit.found = 1'b1;
                o_hit.sel   = 3'(j);
                o_hit.value = nib;
            end
        end
    end

endmodule
`default_nettype wire
